@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing when SYNTH is
// defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/prd_pkg.sv @@
// ----------------------------------------------------------------------------
// Pinhole ray direction package
// Widths, register indexes and pipeline word types shared by the design.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int PIX_W     = 12;
    localparam int DIM_W     = 13;
    localparam int EDGE_W    = 16;
    localparam int ZOOM_W    = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Divider: the remainder stays below twice the cell count.
    localparam int SPAN_W = EDGE_W + 1;
    localparam int NUM_W  = 31;
    localparam int MAG_W  = 30;
    localparam int QUO_W  = 17;
    localparam int REM_W  = 14;
    localparam int DIVR_W = 14;
    localparam int RX_W   = 19;

    // Normalizer.
    localparam int AXIS_W = 16;
    localparam int SQ_W   = 31;
    localparam int SQZ_W  = 30;
    localparam int S_W    = 32;
    localparam int M_W    = 15;
    localparam int TSH    = 2 * M_W;
    localparam int T_W    = SQ_W + TSH;
    localparam int P_W    = T_W;
    localparam int Q_W    = 49;
    localparam int TRY_W  = 67;

    localparam int DIR_W  = 16;
    localparam int DIRZ_W = 15;
    localparam logic [DIRZ_W-1:0] DIRZ_ONE = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_PLANE_LEFT   = 3'd2,
        REG_PLANE_RIGHT  = 3'd3,
        REG_PLANE_TOP    = 3'd4,
        REG_PLANE_BOTTOM = 3'd5,
        REG_FOCAL_ZOOM   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] low;
    } div_lane_t;

    typedef struct packed {
        logic      bad;
        logic      neg_x;
        logic      neg_y;
        div_lane_t lx;
        div_lane_t ly;
    } div_item_t;

    typedef struct packed {
        logic [M_W-1:0]        m;
        logic [P_W-1:0]        p;
        logic signed [Q_W-1:0] q;
        logic [T_W-1:0]        t;
    } norm_lane_t;

    typedef struct packed {
        logic           bad;
        logic           zero;
        logic           neg_x;
        logic           neg_y;
        logic [S_W-1:0] s;
        norm_lane_t     lx;
        norm_lane_t     ly;
        norm_lane_t     lz;
    } norm_item_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [DIRZ_W-1:0]       dir_z;
        logic                    bad_pixel;
    } ray_word_t;

endpackage

@@ design/prd_pixel_if.sv @@
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel coordinate word.
// ----------------------------------------------------------------------------
interface prd_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [prd_pkg::PIX_W-1:0]   pixel_x;
    logic [prd_pkg::PIX_W-1:0]   pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ design/prd_ray_if.sv @@
// ----------------------------------------------------------------------------
// Ray channel
// Valid/ready channel carrying one ray direction word.
// ----------------------------------------------------------------------------
interface prd_ray_if;
    logic                               valid;
    logic                               ready;
    logic signed [prd_pkg::DIR_W-1:0]   dir_x;
    logic signed [prd_pkg::DIR_W-1:0]   dir_y;
    logic [prd_pkg::DIRZ_W-1:0]         dir_z;
    logic                               bad_pixel;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output bad_pixel, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                    input bad_pixel, output ready);
endinterface

@@ design/prd_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Cell offset divider
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module prd_div_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  prd_pkg::div_item_t            in_item,
    input  logic [prd_pkg::DIVR_W-1:0]    div_x,
    input  logic [prd_pkg::DIVR_W-1:0]    div_y,
    output logic                          out_valid,
    output prd_pkg::div_item_t            out_item
);

    localparam int N = prd_pkg::QUO_W;

    // Shift one numerator bit into the remainder and keep the quotient bit.
    function automatic prd_pkg::div_lane_t div_step(prd_pkg::div_lane_t a,
                                                    logic [prd_pkg::DIVR_W-1:0] d);
        logic [prd_pkg::REM_W:0] tr;
        logic                    ge;
        prd_pkg::div_lane_t      r;
        tr    = {a.rem, a.low[N-1]};
        ge    = (tr >= {1'b0, d});
        r.rem = ge ? prd_pkg::REM_W'(tr - {1'b0, d}) : prd_pkg::REM_W'(tr);
        r.low = {a.low[N-2:0], ge};
        return r;
    endfunction

    logic [N-1:0]       v_reg;
    prd_pkg::div_item_t item_reg  [N];
    prd_pkg::div_item_t item_next [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            item_next[i]    = (i == 0) ? in_item : item_reg[(i == 0) ? 0 : i - 1];
            item_next[i].lx = div_step(item_next[i].lx, div_x);
            item_next[i].ly = div_step(item_next[i].ly, div_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = item_reg[N-1];

endmodule

@@ design/prd_norm_pipe.sv @@
// ----------------------------------------------------------------------------
// Direction normalizer
// Pipelined bit-by-bit search for round(a * 2^14 / sqrt(s)), three lanes.
// ----------------------------------------------------------------------------
module prd_norm_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  prd_pkg::norm_item_t  in_item,
    output logic                 out_valid,
    output prd_pkg::norm_item_t  out_item
);

    localparam int N = prd_pkg::M_W;

    // Each lane keeps p = k*k*s and q = k*s for k = 2m-1, so a trial of
    // m + 2^j costs only shifts and adds; it is kept when p does not pass t.
    function automatic prd_pkg::norm_lane_t norm_step(prd_pkg::norm_lane_t a,
                                                      logic [prd_pkg::S_W-1:0] s,
                                                      int j);
        logic signed [prd_pkg::TRY_W-1:0] tp;
        logic signed [prd_pkg::TRY_W-1:0] tq;
        logic signed [prd_pkg::TRY_W-1:0] ts;
        logic signed [prd_pkg::TRY_W-1:0] trial;
        logic signed [prd_pkg::Q_W-1:0]   qs;
        prd_pkg::norm_lane_t              r;
        tp    = $signed(prd_pkg::TRY_W'(a.p));
        tq    = prd_pkg::TRY_W'($signed(a.q)) <<< (j + 2);
        ts    = $signed(prd_pkg::TRY_W'(s)) <<< (2 * j + 2);
        trial = tp + tq + ts;
        qs    = $signed(prd_pkg::Q_W'(s)) <<< (j + 1);
        r     = a;
        if (trial <= $signed(prd_pkg::TRY_W'(a.t)))
        begin
            r.p = prd_pkg::P_W'(trial);
            r.q = $signed(a.q) + qs;
            r.m = a.m | (prd_pkg::M_W'(1) << j);
        end
        return r;
    endfunction

    logic [N-1:0]        v_reg;
    prd_pkg::norm_item_t item_reg  [N];
    prd_pkg::norm_item_t item_next [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            item_next[i]    = (i == 0) ? in_item : item_reg[(i == 0) ? 0 : i - 1];
            item_next[i].lx = norm_step(item_next[i].lx, item_next[i].s, N - 1 - i);
            item_next[i].ly = norm_step(item_next[i].ly, item_next[i].s, N - 1 - i);
            item_next[i].lz = norm_step(item_next[i].lz, item_next[i].s, N - 1 - i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = item_reg[N-1];

endmodule

@@ design/pinhole_ray_direction_generator_core.sv @@
// ----------------------------------------------------------------------------
// Pinhole ray direction generator
// Turns a pixel coordinate into the unit camera-space ray through the center
// of its cell on the image plane, in signed Q1.14.
// ----------------------------------------------------------------------------
// The block takes one pixel word per cycle while pixel ready is high, and
// returns one ray word per pixel, in order. Each pixel word passes in turn
// through the span multiply, the cell offset divider (one quotient bit per
// stage), the cell center, the squares, the length sum, the normalizer
// (one result bit per stage) and the output register. A two-word output
// buffer lets the pipeline keep taking pixels while a finished ray waits;
// pixel ready drops only when both buffer words are occupied. A pixel beyond
// the configured width or height (each clamped to MAX_DIM) gives a zero
// direction with bad_pixel set. Registers are written through
// cfg_we/cfg_index/cfg_wdata and must only change while no word is in flight.
`include "assert_macros.svh"

module pinhole_ray_direction_generator_core #(
    parameter int MAX_DIM = prd_pkg::MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    prd_pixel_if.sink                        pixel,
    prd_ray_if.source                        ray,
    input  logic                             cfg_we,
    input  logic [prd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_W-1:0]        cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [prd_pkg::DIM_W-1:0]         cfg_width_reg;
    logic [prd_pkg::DIM_W-1:0]         cfg_height_reg;
    logic signed [prd_pkg::EDGE_W-1:0] cfg_left_reg;
    logic signed [prd_pkg::EDGE_W-1:0] cfg_right_reg;
    logic signed [prd_pkg::EDGE_W-1:0] cfg_top_reg;
    logic signed [prd_pkg::EDGE_W-1:0] cfg_bottom_reg;
    logic [prd_pkg::ZOOM_W-1:0]        cfg_zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 13'd1024;
            cfg_height_reg <= 13'd768;
            cfg_left_reg   <= -16'sd4096;
            cfg_right_reg  <= 16'sd4096;
            cfg_top_reg    <= 16'sd4096;
            cfg_bottom_reg <= -16'sd4096;
            cfg_zoom_reg   <= 15'd4096;
        end
        else if (cfg_we)
        begin
            unique case (prd_pkg::cfg_reg_t'(cfg_index))
                prd_pkg::REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata[prd_pkg::DIM_W-1:0];
                prd_pkg::REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata[prd_pkg::DIM_W-1:0];
                prd_pkg::REG_PLANE_LEFT:   cfg_left_reg   <= $signed(cfg_wdata);
                prd_pkg::REG_PLANE_RIGHT:  cfg_right_reg  <= $signed(cfg_wdata);
                prd_pkg::REG_PLANE_TOP:    cfg_top_reg    <= $signed(cfg_wdata);
                prd_pkg::REG_PLANE_BOTTOM: cfg_bottom_reg <= $signed(cfg_wdata);
                prd_pkg::REG_FOCAL_ZOOM:   cfg_zoom_reg   <= cfg_wdata[prd_pkg::ZOOM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Cell counts above MAX_DIM are treated as MAX_DIM.
    logic [prd_pkg::DIM_W-1:0] width_eff;
    logic [prd_pkg::DIM_W-1:0] height_eff;

    assign width_eff  = (int'(cfg_width_reg) > MAX_DIM) ?
                        prd_pkg::DIM_W'(MAX_DIM) : cfg_width_reg;
    assign height_eff = (int'(cfg_height_reg) > MAX_DIM) ?
                        prd_pkg::DIM_W'(MAX_DIM) : cfg_height_reg;

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together while the output
    // buffer has a free word.
    // ------------------------------------------------------------------
    logic en;
    logic skid_v_reg;
    logic out_v_reg;

    assign en          = !skid_v_reg;
    assign pixel.ready = en;

    // ------------------------------------------------------------------
    // Stage 0: span times odd pixel index, and the divider's numerator.
    // The offset from the edge is (|num| + n) / (2n), rounded half away.
    // ------------------------------------------------------------------
    logic signed [prd_pkg::SPAN_W-1:0] span_x;
    logic signed [prd_pkg::SPAN_W-1:0] span_y;
    logic signed [prd_pkg::NUM_W-1:0]  num_x;
    logic signed [prd_pkg::NUM_W-1:0]  num_y;
    logic [prd_pkg::MAG_W-1:0]         mag_x;
    logic [prd_pkg::MAG_W-1:0]         mag_y;
    logic [prd_pkg::NUM_W-1:0]         dvd_x;
    logic [prd_pkg::NUM_W-1:0]         dvd_y;
    prd_pkg::div_item_t                s0_next;
    prd_pkg::div_item_t                s0_item_reg;
    logic                              s0_v_reg;

    always_comb
    begin
        span_x = prd_pkg::SPAN_W'(cfg_right_reg) - prd_pkg::SPAN_W'(cfg_left_reg);
        span_y = prd_pkg::SPAN_W'(cfg_bottom_reg) - prd_pkg::SPAN_W'(cfg_top_reg);
        num_x  = span_x * $signed({1'b0, pixel.pixel_x, 1'b1});
        num_y  = span_y * $signed({1'b0, pixel.pixel_y, 1'b1});
        mag_x  = num_x[prd_pkg::NUM_W-1] ? prd_pkg::MAG_W'(-num_x)
                                         : num_x[prd_pkg::MAG_W-1:0];
        mag_y  = num_y[prd_pkg::NUM_W-1] ? prd_pkg::MAG_W'(-num_y)
                                         : num_y[prd_pkg::MAG_W-1:0];
        dvd_x  = prd_pkg::NUM_W'(mag_x) + prd_pkg::NUM_W'(width_eff);
        dvd_y  = prd_pkg::NUM_W'(mag_y) + prd_pkg::NUM_W'(height_eff);

        s0_next.bad    = ({1'b0, pixel.pixel_x} >= width_eff) ||
                         ({1'b0, pixel.pixel_y} >= height_eff);
        s0_next.neg_x  = num_x[prd_pkg::NUM_W-1];
        s0_next.neg_y  = num_y[prd_pkg::NUM_W-1];
        s0_next.lx.rem = dvd_x[prd_pkg::NUM_W-1:prd_pkg::QUO_W];
        s0_next.lx.low = dvd_x[prd_pkg::QUO_W-1:0];
        s0_next.ly.rem = dvd_y[prd_pkg::NUM_W-1:prd_pkg::QUO_W];
        s0_next.ly.low = dvd_y[prd_pkg::QUO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= s0_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: after the last step the low field holds the offset.
    // ------------------------------------------------------------------
    logic               div_v;
    prd_pkg::div_item_t div_item;

    prd_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .in_item   (s0_item_reg),
        .div_x     ({width_eff, 1'b0}),
        .div_y     ({height_eff, 1'b0}),
        .out_valid (div_v),
        .out_item  (div_item)
    );

    // ------------------------------------------------------------------
    // Cell center and its magnitude.
    // ------------------------------------------------------------------
    logic signed [prd_pkg::RX_W-1:0] rx;
    logic signed [prd_pkg::RX_W-1:0] ry;
    logic [prd_pkg::RX_W-1:0]        abs_x;
    logic [prd_pkg::RX_W-1:0]        abs_y;
    logic                            c_v_reg;
    logic                            c_bad_reg;
    logic                            c_neg_x_reg;
    logic                            c_neg_y_reg;
    logic [prd_pkg::AXIS_W-1:0]      c_ax_reg;
    logic [prd_pkg::AXIS_W-1:0]      c_ay_reg;

    always_comb
    begin
        rx = div_item.neg_x ?
             prd_pkg::RX_W'(cfg_left_reg) - $signed({2'b00, div_item.lx.low}) :
             prd_pkg::RX_W'(cfg_left_reg) + $signed({2'b00, div_item.lx.low});
        ry = div_item.neg_y ?
             prd_pkg::RX_W'(cfg_top_reg) - $signed({2'b00, div_item.ly.low}) :
             prd_pkg::RX_W'(cfg_top_reg) + $signed({2'b00, div_item.ly.low});
        abs_x = rx[prd_pkg::RX_W-1] ? prd_pkg::RX_W'(-rx) : prd_pkg::RX_W'(rx);
        abs_y = ry[prd_pkg::RX_W-1] ? prd_pkg::RX_W'(-ry) : prd_pkg::RX_W'(ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= div_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_bad_reg   <= div_item.bad;
            c_neg_x_reg <= rx[prd_pkg::RX_W-1];
            c_neg_y_reg <= ry[prd_pkg::RX_W-1];
            c_ax_reg    <= abs_x[prd_pkg::AXIS_W-1:0];
            c_ay_reg    <= abs_y[prd_pkg::AXIS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Squares of the three components.
    // ------------------------------------------------------------------
    logic                       sq_v_reg;
    logic                       sq_bad_reg;
    logic                       sq_neg_x_reg;
    logic                       sq_neg_y_reg;
    logic [prd_pkg::SQ_W-1:0]   sq_x_reg;
    logic [prd_pkg::SQ_W-1:0]   sq_y_reg;
    logic [prd_pkg::SQZ_W-1:0]  sq_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_bad_reg   <= c_bad_reg;
            sq_neg_x_reg <= c_neg_x_reg;
            sq_neg_y_reg <= c_neg_y_reg;
            sq_x_reg     <= prd_pkg::SQ_W'(c_ax_reg) * prd_pkg::SQ_W'(c_ax_reg);
            sq_y_reg     <= prd_pkg::SQ_W'(c_ay_reg) * prd_pkg::SQ_W'(c_ay_reg);
            sq_z_reg     <= prd_pkg::SQZ_W'(cfg_zoom_reg) * prd_pkg::SQZ_W'(cfg_zoom_reg);
        end
    end

    // ------------------------------------------------------------------
    // Squared length and the normalizer's starting point (m = 0, k = -1).
    // ------------------------------------------------------------------
    logic [prd_pkg::S_W-1:0] len_sq;
    prd_pkg::norm_item_t     nrm_in_next;
    prd_pkg::norm_item_t     nrm_in_reg;
    logic                    nrm_in_v_reg;

    always_comb
    begin
        len_sq = prd_pkg::S_W'(sq_x_reg) + prd_pkg::S_W'(sq_y_reg) +
                 prd_pkg::S_W'(sq_z_reg);

        nrm_in_next.bad   = sq_bad_reg;
        nrm_in_next.zero  = (len_sq == '0);
        nrm_in_next.neg_x = sq_neg_x_reg;
        nrm_in_next.neg_y = sq_neg_y_reg;
        nrm_in_next.s     = len_sq;

        nrm_in_next.lx.m = '0;
        nrm_in_next.lx.p = prd_pkg::P_W'(len_sq);
        nrm_in_next.lx.q = -$signed(prd_pkg::Q_W'(len_sq));
        nrm_in_next.lx.t = prd_pkg::T_W'(sq_x_reg) << prd_pkg::TSH;
        nrm_in_next.ly   = nrm_in_next.lx;
        nrm_in_next.ly.t = prd_pkg::T_W'(sq_y_reg) << prd_pkg::TSH;
        nrm_in_next.lz   = nrm_in_next.lx;
        nrm_in_next.lz.t = prd_pkg::T_W'(sq_z_reg) << prd_pkg::TSH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_in_v_reg <= 1'b0;
        end
        else if (en)
        begin
            nrm_in_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_in_reg <= nrm_in_next;
        end
    end

    logic                nrm_v;
    prd_pkg::norm_item_t nrm_item;

    prd_norm_pipe u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nrm_in_v_reg),
        .in_item   (nrm_in_reg),
        .out_valid (nrm_v),
        .out_item  (nrm_item)
    );

    // ------------------------------------------------------------------
    // Result word: apply signs, and zero out bad pixels and zero vectors.
    // ------------------------------------------------------------------
    prd_pkg::ray_word_t       fin;
    logic signed [prd_pkg::DIR_W-1:0] mag_dx;
    logic signed [prd_pkg::DIR_W-1:0] mag_dy;
    logic                     blank;

    always_comb
    begin
        blank         = nrm_item.bad || nrm_item.zero;
        mag_dx        = $signed(prd_pkg::DIR_W'(nrm_item.lx.m));
        mag_dy        = $signed(prd_pkg::DIR_W'(nrm_item.ly.m));
        fin.dir_x     = blank ? '0 : (nrm_item.neg_x ? -mag_dx : mag_dx);
        fin.dir_y     = blank ? '0 : (nrm_item.neg_y ? -mag_dy : mag_dy);
        fin.dir_z     = blank ? '0 : prd_pkg::DIRZ_W'(nrm_item.lz.m);
        fin.bad_pixel = nrm_item.bad;
    end

    // ------------------------------------------------------------------
    // Output register with one skid word behind it.
    // ------------------------------------------------------------------
    prd_pkg::ray_word_t out_word_reg;
    prd_pkg::ray_word_t skid_word_reg;
    logic               take;
    logic               push;

    assign take = out_v_reg && ray.ready;
    assign push = en && nrm_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || take)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || take)
            begin
                out_word_reg <= fin;
            end
            else
            begin
                skid_word_reg <= fin;
            end
        end
    end

    assign ray.valid     = out_v_reg;
    assign ray.dir_x     = out_word_reg.dir_x;
    assign ray.dir_y     = out_word_reg.dir_y;
    assign ray.dir_z     = out_word_reg.dir_z;
    assign ray.bad_pixel = out_word_reg.bad_pixel;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg, "skid word without output word")
    `ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, !en && nrm_v, nrm_v, "stalled pipeline dropped a word")
    `ASSERT_IMPLIES(a_dir_z_bound, clk, rst_n, ray.valid, ray.dir_z <= prd_pkg::DIRZ_ONE, "dir_z above one")

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pinhole ray direction generator testbench
// Drives pixel words into the core under several register settings and checks
// every ray word against an exact integer predictor or a typed directed result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that maps to no register; a write to it must be ignored.
    localparam logic [prd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
    // Idle wait after the last owed ray is back, before the next register write.
    localparam int DRAIN_CYCLES = 50;
    // Cycles with no accepted word before the run is declared hung.
    localparam int HANG_LIMIT = 5000;
    localparam int DIM_CLAMP = 4096;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [prd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [prd_pkg::CFG_W-1:0] cfg_wdata;

    prd_pixel_if pix ();
    prd_ray_if ray ();

    pinhole_ray_direction_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix),
        .ray       (ray),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the camera registers, as the block should hold them.
    logic [prd_pkg::DIM_W-1:0]         cam_width;
    logic [prd_pkg::DIM_W-1:0]         cam_height;
    logic signed [prd_pkg::EDGE_W-1:0] cam_left;
    logic signed [prd_pkg::EDGE_W-1:0] cam_right;
    logic signed [prd_pkg::EDGE_W-1:0] cam_top;
    logic signed [prd_pkg::EDGE_W-1:0] cam_bottom;
    logic [prd_pkg::ZOOM_W-1:0]        cam_zoom;

    // Rays still owed by the block, oldest first.
    prd_pkg::ray_word_t pending_rays[$];

    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned rays_seen;
    int unsigned bad_rays_seen;
    int unsigned hang_count;
    bit          steady_sink;   // when set, the ray side never stalls

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Edge plus span*(2i+1)/(2n), with the offset rounded half away from zero.
    function automatic longint cell_center(longint edge_pos, longint span,
                                           longint idx, longint cells);
        longint num;
        longint mag;
        longint off;
        num = span * (2 * idx + 1);
        mag = (num < 0) ? -num : num;
        off = (mag + cells) / (2 * cells);
        return (num < 0) ? edge_pos - off : edge_pos + off;
    endfunction

    // Nearest Q1.14 value of a/sqrt(len_sq), found by bisection on the exact
    // comparison (2q-1)^2 * len_sq <= (2a * 2^14)^2, so ties round upward.
    function automatic longint unit_q14(longint unsigned a, longint unsigned len_sq);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned k;
        target = (a << 15) * (a << 15);
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            if (k * k * len_sq <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function automatic prd_pkg::ray_word_t predict_ray(logic [prd_pkg::PIX_W-1:0] px,
                                                       logic [prd_pkg::PIX_W-1:0] py);
        prd_pkg::ray_word_t r;
        longint         cols;
        longint         rows;
        longint         rx;
        longint         ry;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned zz;
        longint unsigned len_sq;
        longint         qx;
        longint         qy;
        r = '0;
        cols = (cam_width > DIM_CLAMP) ? DIM_CLAMP : longint'(cam_width);
        rows = (cam_height > DIM_CLAMP) ? DIM_CLAMP : longint'(cam_height);
        if (longint'(px) >= cols || longint'(py) >= rows)
        begin
            r.bad_pixel = 1'b1;
            return r;
        end
        rx = cell_center(cam_left, longint'(cam_right) - longint'(cam_left), px, cols);
        ry = cell_center(cam_top, longint'(cam_bottom) - longint'(cam_top), py, rows);
        ax = (rx < 0) ? -rx : rx;
        ay = (ry < 0) ? -ry : ry;
        zz = cam_zoom;
        len_sq = zz * zz + ax * ax + ay * ay;
        // A zero-length vector leaves the direction at zero, with no error flag.
        if (len_sq == 0)
            return r;
        qx = unit_q14(ax, len_sq);
        qy = unit_q14(ay, len_sq);
        r.dir_x = prd_pkg::DIR_W'((rx < 0) ? -qx : qx);
        r.dir_y = prd_pkg::DIR_W'((ry < 0) ? -qy : qy);
        r.dir_z = prd_pkg::DIRZ_W'(unit_q14(zz, len_sq));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Register writes: the port and the shadow copy change together.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [prd_pkg::CFG_IDX_W-1:0] idx,
                             logic [prd_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            prd_pkg::REG_IMAGE_WIDTH:  cam_width  = value[prd_pkg::DIM_W-1:0];
            prd_pkg::REG_IMAGE_HEIGHT: cam_height = value[prd_pkg::DIM_W-1:0];
            prd_pkg::REG_PLANE_LEFT:   cam_left   = value;
            prd_pkg::REG_PLANE_RIGHT:  cam_right  = value;
            prd_pkg::REG_PLANE_TOP:    cam_top    = value;
            prd_pkg::REG_PLANE_BOTTOM: cam_bottom = value;
            prd_pkg::REG_FOCAL_ZOOM:   cam_zoom   = value[prd_pkg::ZOOM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(int w, int h, int l, int r, int t, int b, int z);
        write_reg(prd_pkg::REG_IMAGE_WIDTH,  prd_pkg::CFG_W'(w));
        write_reg(prd_pkg::REG_IMAGE_HEIGHT, prd_pkg::CFG_W'(h));
        write_reg(prd_pkg::REG_PLANE_LEFT,   prd_pkg::CFG_W'(l));
        write_reg(prd_pkg::REG_PLANE_RIGHT,  prd_pkg::CFG_W'(r));
        write_reg(prd_pkg::REG_PLANE_TOP,    prd_pkg::CFG_W'(t));
        write_reg(prd_pkg::REG_PLANE_BOTTOM, prd_pkg::CFG_W'(b));
        write_reg(prd_pkg::REG_FOCAL_ZOOM,   prd_pkg::CFG_W'(z));
    endtask

    // Holds the pixel side until every owed ray is back and the pipe is empty.
    task automatic drain_pipe();
        pix.valid <= 1'b0;
        wait (pending_rays.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Pixel side: a random idle gap, possibly none, then hold the word until it
    // is taken. Valid is only lowered when a gap follows, so a back-to-back
    // word never sees valid dropped and raised in one time step.
    // ------------------------------------------------------------------------
    task automatic send_pixel(logic [prd_pkg::PIX_W-1:0] px, logic [prd_pkg::PIX_W-1:0] py,
                              bit typed, prd_pkg::ray_word_t typed_ray);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= px;
        pix.pixel_y <= py;
        do
            @(posedge clk);
        while (!pix.ready);
        pending_rays.push_back(typed ? typed_ray : predict_ray(px, py));
        pixels_sent++;
    endtask

    // Mostly pixels inside the image, the rest anywhere in the field range.
    task automatic send_random(int count);
        int cols;
        int rows;
        logic [prd_pkg::PIX_W-1:0] px;
        logic [prd_pkg::PIX_W-1:0] py;
        cols = (cam_width > DIM_CLAMP) ? DIM_CLAMP : cam_width;
        rows = (cam_height > DIM_CLAMP) ? DIM_CLAMP : cam_height;
        for (int i = 0; i < count; i++)
        begin
            if (cols > 0 && rows > 0 && $urandom_range(0, 99) < 85)
            begin
                px = prd_pkg::PIX_W'($urandom_range(0, cols - 1));
                py = prd_pkg::PIX_W'($urandom_range(0, rows - 1));
            end
            else
            begin
                px = prd_pkg::PIX_W'($urandom());
                py = prd_pkg::PIX_W'($urandom());
            end
            send_pixel(px, py, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Ray side: each word waits through a random stall, possibly none, unless the
    // sink is steady.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady_sink ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                ray.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            ray.ready <= 1'b1;
            do
                @(posedge clk);
            while (!ray.valid);
        end
    end

    // Compare each accepted ray word with the oldest owed ray, field by field.
    always @(posedge clk)
    begin
        prd_pkg::ray_word_t want;
        if (rst_n && ray.valid && ray.ready)
        begin
            rays_seen++;
            if (ray.bad_pixel)
                bad_rays_seen++;
            if (pending_rays.size() == 0)
            begin
                $error("ray word with no pixel outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_rays.pop_front();
                if (ray.dir_x !== want.dir_x)
                begin
                    $error("dir_x: expected %0d, got %0d", want.dir_x, ray.dir_x);
                    mismatches++;
                end
                if (ray.dir_y !== want.dir_y)
                begin
                    $error("dir_y: expected %0d, got %0d", want.dir_y, ray.dir_y);
                    mismatches++;
                end
                if (ray.dir_z !== want.dir_z)
                begin
                    $error("dir_z: expected %0d, got %0d", want.dir_z, ray.dir_z);
                    mismatches++;
                end
                if (ray.bad_pixel !== want.bad_pixel)
                begin
                    $error("bad_pixel: expected %0b, got %0b",
                           want.bad_pixel, ray.bad_pixel);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any accepted word on either side means a hang.
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (ray.valid && ray.ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("hang: no word moved for %0d cycles", HANG_LIMIT);
            $display("** pinhole_ray_direction_generator_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed pixels under the reset camera (1024 x 768, plane -1..1, zoom 1).
    // Rows marked typed carry a result read straight off the spec; the others
    // go through the predictor.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [prd_pkg::PIX_W-1:0] px;
        logic [prd_pkg::PIX_W-1:0] py;
        bit                        typed;
        prd_pkg::ray_word_t        want;
    } pixel_row_t;

    localparam prd_pkg::ray_word_t BAD_RAY =
        '{dir_x: '0, dir_y: '0, dir_z: '0, bad_pixel: 1'b1};

    pixel_row_t directed_rows[] = '{
        '{12'd0,    12'd0,    1'b0, '0},
        '{12'd1023, 12'd767,  1'b0, '0},
        '{12'd1023, 12'd0,    1'b0, '0},
        '{12'd0,    12'd767,  1'b0, '0},
        '{12'd511,  12'd383,  1'b0, '0},
        '{12'd512,  12'd384,  1'b0, '0},
        '{12'd1024, 12'd0,    1'b1, BAD_RAY},
        '{12'd0,    12'd768,  1'b1, BAD_RAY},
        '{12'd1024, 12'd768,  1'b1, BAD_RAY},
        '{12'd4095, 12'd4095, 1'b1, BAD_RAY},
        '{12'd4095, 12'd0,    1'b1, BAD_RAY},
        '{12'd0,    12'd4095, 1'b1, BAD_RAY},
        '{12'd2730, 12'd1365, 1'b1, BAD_RAY},
        '{12'd341,  12'd682,  1'b0, '0},
        '{12'd682,  12'd341,  1'b0, '0}
    };

    initial
    begin
        pix.valid   = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        ray.ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = prd_pkg::REG_IMAGE_WIDTH;
        cfg_wdata   = '0;
        mismatches  = 0;
        pixels_sent = 0;
        rays_seen   = 0;
        bad_rays_seen = 0;
        hang_count  = 0;
        steady_sink = 1'b0;
        cam_width   = 13'd1024;
        cam_height  = 13'd768;
        cam_left    = -16'sd4096;
        cam_right   = 16'sd4096;
        cam_top     = 16'sd4096;
        cam_bottom  = -16'sd4096;
        cam_zoom    = 15'd4096;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].py,
                       directed_rows[i].typed, directed_rows[i].want);
        send_random(120);
        // The sender waits here for every owed ray before moving on.
        drain_pipe();

        // Single cell, extreme plane and widest zoom; a write to the spare
        // index must leave the camera untouched.
        set_camera(1, 1, -32768, 32767, 32767, -32768, 32767);
        write_reg(REG_NONE, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 1'b0, '0);
        send_pixel(12'd1, 12'd0, 1'b1, BAD_RAY);
        send_pixel(12'd0, 12'd1, 1'b1, BAD_RAY);
        send_random(60);
        drain_pipe();

        // Dimensions beyond the clamp, so all of 0..4095 lies inside.
        set_camera(8191, 4097, 32767, -32768, -32768, 32767, 1);
        steady_sink = 1'b1;
        send_pixel(12'd4095, 12'd4095, 1'b0, '0);
        send_pixel(12'd0, 12'd0, 1'b0, '0);
        send_random(150);
        steady_sink = 1'b0;
        drain_pipe();

        // Zero zoom on a collapsed plane gives a zero-length vector.
        set_camera(4, 4, 0, 0, 0, 0, 0);
        send_pixel(12'd0, 12'd0, 1'b1, '0);
        send_pixel(12'd3, 12'd3, 1'b1, '0);
        send_random(30);
        drain_pipe();

        // Zero width and then zero height: every pixel is bad.
        set_camera(0, 100, -4096, 4096, 4096, -4096, 4096);
        send_pixel(12'd0, 12'd0, 1'b1, BAD_RAY);
        send_random(30);
        drain_pipe();
        set_camera(100, 0, -4096, 4096, 4096, -4096, 4096);
        send_pixel(12'd0, 12'd0, 1'b1, BAD_RAY);
        send_random(30);
        drain_pipe();

        // Zero zoom on an ordinary plane: rays lie in the image plane.
        set_camera(4096, 4096, -32768, 32767, 32767, -32768, 0);
        send_random(100);
        drain_pipe();

        // Random cameras, mostly with small images.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_camera(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(1, 64),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(1, 64),
                       $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom_range(0, 32767));
            steady_sink = (ph % 3 == 0);
            send_random(100);
            steady_sink = 1'b0;
            drain_pipe();
        end

        pix.valid <= 1'b0;
        wait (pending_rays.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels over 15 camera settings; %0d rays checked, %0d flagged bad.",
                 pixels_sent, rays_seen, bad_rays_seen);
        if (mismatches == 0)
            $display("** pinhole_ray_direction_generator_core: PASSED **");
        else
            $display("** pinhole_ray_direction_generator_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/prd_pkg.sv
design/prd_pixel_if.sv
design/prd_ray_if.sv
design/prd_div_pipe.sv
design/prd_norm_pipe.sv
design/pinhole_ray_direction_generator_core.sv
dv/tb_top.sv
